>>> hw/rtl/ipv4wb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 wildcard ban matcher package
// Request codes for the top level, and the scan token and write-port struct
// shared by the cells and the top level, plus the per-octet wildcard compare.
// ----------------------------------------------------------------------------
package ipv4wb_pkg;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [31:0] OCTET_MASK_0 = 32'h0000_00ff;
    localparam logic [31:0] OCTET_MASK_1 = 32'h0000_ff00;
    localparam logic [31:0] OCTET_MASK_2 = 32'h00ff_0000;
    localparam logic [31:0] OCTET_MASK_3 = 32'hff00_0000;

    // Query token that walks down the chain, one cell per cycle.
    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic        hit;
    } scan_token_t;

    // Broadcast write port for appends.
    typedef struct packed {
        logic        en;
        logic [31:0] address;
        logic [3:0]  wild_mask;
    } entry_write_t;

    // An entry matches when every octet that is not wildcarded is equal.
    function automatic logic entry_match(input logic [31:0] stored,
                                         input logic [3:0]  wild,
                                         input logic [31:0] addr);
        logic [31:0] care;
        care = (wild[0] ? 32'h0 : OCTET_MASK_0) |
               (wild[1] ? 32'h0 : OCTET_MASK_1) |
               (wild[2] ? 32'h0 : OCTET_MASK_2) |
               (wild[3] ? 32'h0 : OCTET_MASK_3);
        return ((stored ^ addr) & care) == 32'h0;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ipv4wb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 wildcard ban matcher cell
// Holds one list entry and passes the query token to the next cell, folding
// in its own match when the entry lies below the fill count.
// ----------------------------------------------------------------------------
module ipv4wb_cell
    import ipv4wb_pkg::*;
#(
    parameter int CNT_W      = 7,
    parameter int CELL_INDEX = 0
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [CNT_W-1:0] entry_count,
    input  wire entry_write_t wr,
    input  wire scan_token_t  tok_in,
    output scan_token_t       tok_out
);

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(CELL_INDEX);

    logic [31:0] addr_reg;
    logic [3:0]  wild_reg;
    scan_token_t tok_reg;
    scan_token_t tok_next;
    logic        in_use;

    assign in_use = entry_count > MY_INDEX;

    always_comb begin
        tok_next     = tok_in;
        tok_next.hit = tok_in.hit | (in_use & entry_match(addr_reg, wild_reg, tok_in.address));
    end

    always_ff @(posedge aclk) begin
        if (wr.en && entry_count == MY_INDEX) begin
            addr_reg <= wr.address;
            wild_reg <= wr.wild_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.address <= tok_next.address;
        tok_reg.hit     <= tok_next.hit;
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

>>> hw/rtl/ipv4_wildcard_ban_matcher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 wildcard ban matcher core
// Keeps a ban list of IPv4 addresses with per-octet wildcards in a chain of
// cells and answers clear, append and query requests, one result each.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ channel: tuser carries the request type (clear,
// append, query), tdata the address and the wildcard mask. Every request
// yields exactly one result on the m_ channel: bit 0 is the ban hit of a
// query, bit 1 is set when an append was dropped because the list is full.
// The result of a clear or append request is valid on the cycle after its
// acceptance. A query enters the first cell of the chain and moves one
// cell per cycle, each cell folding in its own compare, and its result is
// registered when the token leaves the tail cell. The chain length sets
// the query time; one request is in flight at a time, so the next
// request is taken the cycle after the previous result is registered,
// provided the result register is free or being read in that same cycle.
// Reset empties the list (the fill count returns to zero) and drops any
// request in flight; entry storage itself is not cleared, and entries at or
// beyond the count are never compared. When the receiver stalls, the result
// stays held in the output register and no further request is accepted until
// it is taken.
// ----------------------------------------------------------------------------
module ipv4_wildcard_ban_matcher_core
    import ipv4wb_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] address, [35:32] wild_mask, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [0] is_banned, [1] status, rest zero
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic             m_tvalid_reg;
    logic             is_banned_reg;
    logic             status_reg;

    logic             accept;
    logic [1:0]       req_type;
    logic [31:0]      address;
    logic [3:0]       wild_mask;
    logic             list_full;
    logic             result_load;
    entry_write_t     wr;

    // Token entering the cell in front of index i; index MAX_ENTRIES is the tail.
    scan_token_t      chain [MAX_ENTRIES + 1];

    assign req_type  = s_tuser;
    assign address   = s_tdata[31:0];
    assign wild_mask = s_tdata[35:32];

    // One request at a time; the output register must be free or draining.
    // Nothing is taken while reset is held.
    assign s_tready  = aresetn && (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign list_full = (count_reg == CNT_MAX);

    // A result is loaded by any non-query request, or when the query token
    // leaves the tail of the chain.
    assign result_load = (accept && (req_type != REQ_QUERY)) ||
                         ((state_reg == ST_SCAN) && chain[MAX_ENTRIES].valid);

    assign wr.en        = accept && (req_type == REQ_APPEND) && !list_full;
    assign wr.address   = address;
    assign wr.wild_mask = wild_mask;

    // A query is injected at the head of the chain with no hit yet.
    assign chain[0].valid   = accept && (req_type == REQ_QUERY);
    assign chain[0].address = address;
    assign chain[0].hit     = 1'b0;

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        ipv4wb_cell #(
            .CNT_W      (CNT_W),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .entry_count (count_reg),
            .wr          (wr),
            .tok_in      (chain[i]),
            .tok_out     (chain[i + 1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (result_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (req_type)
                            REQ_CLEAR: begin
                                count_reg     <= '0;
                                is_banned_reg <= 1'b0;
                                status_reg    <= 1'b0;
                            end
                            REQ_APPEND: begin
                                if (!list_full) begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                                is_banned_reg <= 1'b0;
                                status_reg    <= list_full;
                            end
                            REQ_QUERY: begin
                                state_reg <= ST_SCAN;
                            end
                            default: begin
                                // Unused request type: no change, plain result.
                                is_banned_reg <= 1'b0;
                                status_reg    <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    // The token leaves the last cell carrying the OR of all matches.
                    if (chain[MAX_ENTRIES].valid) begin
                        state_reg     <= ST_IDLE;
                        is_banned_reg <= chain[MAX_ENTRIES].hit;
                        status_reg    <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, status_reg, is_banned_reg};

endmodule
`default_nettype wire
